// ===== hdl/rcrs_pkg.sv =====
// Shared constants, types and ring distance functions for the ring route selector.
package rcrs_pkg;

    localparam int MAX_CHIPLETS = 32;
    localparam int MAX_GATEWAYS = 8;
    localparam int NODE_W       = 6;
    localparam int DIST_W       = $clog2(MAX_CHIPLETS);
    localparam int GCNT_W       = 4;
    localparam int LIST_W       = 48;
    localparam int CFG_IDX_W    = 2;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [DIST_W-1:0] t_dist;

    localparam t_node ROUTE_HOST = t_node'(0);
    localparam t_node ROUTE_CCW  = t_node'(1);
    localparam t_node ROUTE_CW   = t_node'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHIPLET_COUNT = 2'd0,
        CFG_GATEWAY_COUNT = 2'd1,
        CFG_GATEWAY_LIST  = 2'd2
    } t_cfg_reg;

    // gateway candidate in the minimum search
    typedef struct packed {
        logic  have;
        t_dist hops;
        t_node id;
    } t_cand;

    // result of the gateway scan
    typedef struct packed {
        logic  have;
        logic  is_gw;
        t_node id;
    } t_gw_pick;

    // per-word control carried alongside the gateway scan
    typedef struct packed {
        logic  ok;
        logic  host;
        logic  from_host;
        t_node src;
        t_node n;
        t_node pair_dir;
    } t_ctl;

    // clockwise hop count from a to b on a ring of n
    function automatic t_dist ring_cw(input t_node a, input t_node b, input t_node n);
        logic [NODE_W:0] t;
        if (b >= a) begin
            t = {1'b0, b} - {1'b0, a};
        end else begin
            t = {1'b0, b} + {1'b0, n} - {1'b0, a};
        end
        return t[DIST_W-1:0];
    endfunction

    // direction from chiplet a to chiplet b, tie goes clockwise
    function automatic t_node ring_dir(input t_node a, input t_node b, input t_node n);
        t_dist           cw;
        logic [NODE_W:0] two_cw;
        cw     = ring_cw(a, b, n);
        two_cw = (NODE_W+1)'(cw) << 1;
        if (n == t_node'(2)) begin
            return (a == t_node'(1)) ? ROUTE_CW : ROUTE_CCW;
        end
        return (two_cw <= {1'b0, n}) ? ROUTE_CW : ROUTE_CCW;
    endfunction

endpackage

// ===== hdl/rcrs_gw_pick.sv =====
// Four-stage gateway scan: ring distance per entry, then a registered minimum tree.
module rcrs_gw_pick (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  rcrs_pkg::t_node          i_chip,
    input  rcrs_pkg::t_node          i_n,
    input  logic [rcrs_pkg::GCNT_W-1:0] i_gc,
    input  logic [rcrs_pkg::LIST_W-1:0] i_list,
    output rcrs_pkg::t_gw_pick       o_pick
);

    logic             r1_vld [rcrs_pkg::MAX_GATEWAYS];
    rcrs_pkg::t_dist  r1_cw  [rcrs_pkg::MAX_GATEWAYS];
    rcrs_pkg::t_node  r1_id  [rcrs_pkg::MAX_GATEWAYS];
    rcrs_pkg::t_node  r1_n;

    rcrs_pkg::t_cand  r2_cand  [rcrs_pkg::MAX_GATEWAYS];
    logic [rcrs_pkg::MAX_GATEWAYS-1:0] r2_match;

    rcrs_pkg::t_cand  r3_cand [2];
    logic             r3_gw;

    rcrs_pkg::t_cand  n_l1 [4];
    rcrs_pkg::t_cand  n_l2 [2];
    rcrs_pkg::t_cand  n_best;

    // earlier entry wins unless the later one is strictly nearer
    function automatic rcrs_pkg::t_cand pick(input rcrs_pkg::t_cand a,
                                             input rcrs_pkg::t_cand b);
        if (a.have && (!b.have || a.hops <= b.hops)) begin
            return a;
        end
        return b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_n <= i_n;
            for (int i = 0; i < rcrs_pkg::MAX_GATEWAYS; i++) begin
                r1_id[i]  <= i_list[i*rcrs_pkg::NODE_W +: rcrs_pkg::NODE_W];
                r1_vld[i] <= (rcrs_pkg::GCNT_W'(i) < i_gc)
                          && (i_list[i*rcrs_pkg::NODE_W +: rcrs_pkg::NODE_W]
                              != rcrs_pkg::t_node'(0))
                          && (i_list[i*rcrs_pkg::NODE_W +: rcrs_pkg::NODE_W] <= i_n);
                r1_cw[i]  <= rcrs_pkg::ring_cw(
                                 i_list[i*rcrs_pkg::NODE_W +: rcrs_pkg::NODE_W],
                                 i_chip, i_n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < rcrs_pkg::MAX_GATEWAYS; i++) begin
                r2_cand[i].have <= r1_vld[i];
                r2_cand[i].id   <= r1_id[i];
                if (((rcrs_pkg::NODE_W+1)'(r1_cw[i]) << 1) <= {1'b0, r1_n}) begin
                    r2_cand[i].hops <= r1_cw[i];
                end else begin
                    r2_cand[i].hops <= rcrs_pkg::DIST_W'(r1_n - rcrs_pkg::NODE_W'(r1_cw[i]));
                end
                r2_match[i] <= r1_vld[i] && (r1_cw[i] == rcrs_pkg::t_dist'(0));
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_l1[j] = pick(r2_cand[2*j], r2_cand[2*j+1]);
        end
        for (int k = 0; k < 2; k++) begin
            n_l2[k] = pick(n_l1[2*k], n_l1[2*k+1]);
        end
        n_best = pick(r3_cand[0], r3_cand[1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_cand[0]   <= n_l2[0];
            r3_cand[1]   <= n_l2[1];
            r3_gw        <= |r2_match;
            o_pick.have  <= n_best.have;
            o_pick.id    <= n_best.id;
            o_pick.is_gw <= r3_gw;
        end
    end

endmodule

// ===== hdl/ring_chiplet_route_select.sv =====
// Top level: ring route selector with config registers and a five-stage pipeline.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  query   | in        | i_in_valid / o_in_stall   | i_source_node, i_dest_node
//  route   | out       | o_out_valid / i_out_stall | o_route_found, o_route_value
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One word per cycle while the result is not stalled.
//  Five register stages: distance, fold, two tree levels, last tree level, route.
//  A stalled result freezes every stage; i_out_stall reaches o_in_stall directly.
//  Synchronous active-low reset clears stage valids, gateway count and list.
module ring_chiplet_route_select (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rcrs_pkg::t_node             i_source_node,
    input  rcrs_pkg::t_node             i_dest_node,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_route_found,
    output rcrs_pkg::t_node             o_route_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rcrs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcrs_pkg::LIST_W-1:0] i_cfg_data
);

    localparam int STAGES = 4;

    logic [rcrs_pkg::NODE_W-1:0] r_chiplet_count;
    logic [rcrs_pkg::GCNT_W-1:0] r_gateway_count;
    logic [rcrs_pkg::LIST_W-1:0] r_gateway_list;

    logic                        en;
    rcrs_pkg::t_node             n_n;
    logic [rcrs_pkg::GCNT_W-1:0] n_gc;
    rcrs_pkg::t_node             n_chip;
    rcrs_pkg::t_ctl              n_ctl;

    logic                        r_vld [STAGES];
    rcrs_pkg::t_ctl              r_ctl [STAGES];
    rcrs_pkg::t_gw_pick          pick;

    logic                        n_found;
    rcrs_pkg::t_node             n_value;

    assign o_cfg_ready = 1'b1;
    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chiplet_count <= rcrs_pkg::t_node'(2);
            r_gateway_count <= '0;
            r_gateway_list  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rcrs_pkg::CFG_CHIPLET_COUNT: begin
                    r_chiplet_count <= i_cfg_data[rcrs_pkg::NODE_W-1:0];
                end
                rcrs_pkg::CFG_GATEWAY_COUNT: begin
                    r_gateway_count <= i_cfg_data[rcrs_pkg::GCNT_W-1:0];
                end
                rcrs_pkg::CFG_GATEWAY_LIST: begin
                    r_gateway_list <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_n  = (r_chiplet_count > rcrs_pkg::t_node'(rcrs_pkg::MAX_CHIPLETS))
             ? rcrs_pkg::t_node'(rcrs_pkg::MAX_CHIPLETS) : r_chiplet_count;
        n_gc = (r_gateway_count > rcrs_pkg::GCNT_W'(rcrs_pkg::MAX_GATEWAYS))
             ? rcrs_pkg::GCNT_W'(rcrs_pkg::MAX_GATEWAYS) : r_gateway_count;
        n_ctl.from_host = (i_source_node == rcrs_pkg::t_node'(0));
        n_ctl.host      = n_ctl.from_host || (i_dest_node == rcrs_pkg::t_node'(0));
        n_ctl.ok        = (i_source_node != i_dest_node)
                       && (i_source_node <= n_n) && (i_dest_node <= n_n);
        n_ctl.src       = i_source_node;
        n_ctl.n         = n_n;
        n_ctl.pair_dir  = rcrs_pkg::ring_dir(i_source_node, i_dest_node, n_n);
        n_chip          = n_ctl.from_host ? i_dest_node : i_source_node;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            o_out_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0] <= n_ctl;
            for (int s = 1; s < STAGES; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
            o_route_found <= n_found;
            o_route_value <= n_value;
        end
    end

    rcrs_gw_pick u_gw_pick (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_chip (n_chip),
        .i_n    (n_n),
        .i_gc   (n_gc),
        .i_list (r_gateway_list),
        .o_pick (pick)
    );

    always_comb begin
        n_found = 1'b0;
        n_value = rcrs_pkg::ROUTE_HOST;
        if (r_ctl[STAGES-1].ok) begin
            if (!r_ctl[STAGES-1].host) begin
                n_found = 1'b1;
                n_value = r_ctl[STAGES-1].pair_dir;
            end else if (pick.have) begin
                n_found = 1'b1;
                if (r_ctl[STAGES-1].from_host) begin
                    n_value = pick.id;
                end else if (pick.is_gw) begin
                    n_value = rcrs_pkg::ROUTE_HOST;
                end else begin
                    n_value = rcrs_pkg::ring_dir(r_ctl[STAGES-1].src, pick.id,
                                                 r_ctl[STAGES-1].n);
                end
            end
        end
    end

endmodule

// ===== hdl/rcrs_checker.sv =====
// Port-level checks for the ring route selector, bound to the top level.
module rcrs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input logic            o_route_found,
    input rcrs_pkg::t_node o_route_value
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // input backs off only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no stalled result");

    // no route carries a zero value
    a_no_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_route_found |-> o_route_value == rcrs_pkg::ROUTE_HOST)
        else $error("no-route word with non-zero value");

endmodule

bind ring_chiplet_route_select rcrs_checker u_rcrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_route_found (o_route_found),
    .o_route_value (o_route_value)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the ring route selector: queued queries, stalls, config phases.
`timescale 1ns / 100ps

module testbench;

    localparam logic [rcrs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        rcrs_pkg::t_node src;
        rcrs_pkg::t_node dst;
    } t_query;

    typedef struct {
        rcrs_pkg::t_node src;
        rcrs_pkg::t_node dst;
        logic            found;
        rcrs_pkg::t_node value;
    } t_route;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    rcrs_pkg::t_node                i_source_node;
    rcrs_pkg::t_node                i_dest_node;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic                           o_route_found;
    rcrs_pkg::t_node                o_route_value;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rcrs_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [rcrs_pkg::LIST_W-1:0]    i_cfg_data;

    // shadow copy of the config registers
    logic [5:0]                  ring_size;
    logic [3:0]                  gw_count;
    logic [rcrs_pkg::LIST_W-1:0] gw_list;

    t_query pending_queries[$];
    t_route expected_routes[$];
    int     queries_queued;
    int     queries_taken;
    int     errors;
    int     gap_left;
    int     stall_left;
    bit     steady;
    logic   query_taken_q;
    logic   route_taken_q;

    ring_chiplet_route_select u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_source_node (i_source_node),
        .i_dest_node   (i_dest_node),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_route_found (o_route_found),
        .o_route_value (o_route_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

    function automatic int cw_hops(int a, int b, int n);
        return (b + n - a) % n;
    endfunction

    function automatic rcrs_pkg::t_node heading(int a, int b, int n);
        if (n == 2) begin
            return (a == 1) ? rcrs_pkg::ROUTE_CW : rcrs_pkg::ROUTE_CCW;
        end
        return (cw_hops(a, b, n) <= cw_hops(b, a, n)) ? rcrs_pkg::ROUTE_CW
                                                      : rcrs_pkg::ROUTE_CCW;
    endfunction

    function automatic int ring_limit();
        return (ring_size > rcrs_pkg::MAX_CHIPLETS) ? rcrs_pkg::MAX_CHIPLETS
                                                    : int'(ring_size);
    endfunction

    function automatic t_route predict_route(rcrs_pkg::t_node src, rcrs_pkg::t_node dst);
        int              n;
        int              gc;
        int              c;
        int              g;
        int              d;
        int              best_d;
        bit              have;
        bit              is_gw;
        rcrs_pkg::t_node best_id;
        t_route          r;
        n       = ring_limit();
        gc      = (gw_count > rcrs_pkg::MAX_GATEWAYS) ? rcrs_pkg::MAX_GATEWAYS
                                                      : int'(gw_count);
        r.src   = src;
        r.dst   = dst;
        r.found = 1'b0;
        r.value = '0;
        have    = 1'b0;
        is_gw   = 1'b0;
        best_id = '0;
        best_d  = 0;
        if (src != dst && src <= n && dst <= n) begin
            if (src != 0 && dst != 0) begin
                r.found = 1'b1;
                r.value = heading(src, dst, n);
            end else begin
                c = (src == 0) ? int'(dst) : int'(src);
                for (int i = 0; i < gc; i++) begin
                    g = int'(gw_list[6*i +: 6]);
                    if (g == 0 || g > n) continue;
                    if (g == c) is_gw = 1'b1;
                    d = cw_hops(g, c, n);
                    if (cw_hops(c, g, n) < d) d = cw_hops(c, g, n);
                    if (!have || d < best_d) begin
                        have    = 1'b1;
                        best_d  = d;
                        best_id = rcrs_pkg::t_node'(g);
                    end
                end
                if (have) begin
                    r.found = 1'b1;
                    if (src == 0) begin
                        r.value = best_id;
                    end else if (is_gw) begin
                        r.value = rcrs_pkg::ROUTE_HOST;
                    end else begin
                        r.value = heading(src, best_id, n);
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // query driver
    always @(negedge i_clk) begin : query_drv
        t_query q;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !query_taken_q) begin
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left--;
        end else if (pending_queries.size() != 0) begin
            q = pending_queries.pop_front();
            i_in_valid    <= 1'b1;
            i_source_node <= q.src;
            i_dest_node   <= q.dst;
            gap_left = steady ? 0 : $urandom_range(0, 3);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (route_taken_q) stall_left = steady ? 0 : $urandom_range(0, 3);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin : route_mon
        t_route want;
        query_taken_q <= i_rst_n && i_in_valid && !o_in_stall;
        route_taken_q <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_routes.push_back(predict_route(i_source_node, i_dest_node));
            queries_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_routes.size() == 0) begin
                report_mismatch("route word with no query outstanding");
            end else begin
                want = expected_routes.pop_front();
                if (o_route_found !== want.found) begin
                    report_mismatch($sformatf("%0d->%0d found %b, want %b",
                        want.src, want.dst, o_route_found, want.found));
                end
                if (o_route_value !== want.value) begin
                    report_mismatch($sformatf("%0d->%0d value %0d, want %0d",
                        want.src, want.dst, o_route_value, want.value));
                end
            end
        end
    end

    task automatic queue_query(input rcrs_pkg::t_node src, input rcrs_pkg::t_node dst);
        t_query q;
        q.src = src;
        q.dst = dst;
        pending_queries.push_back(q);
        queries_queued++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (queries_taken != queries_queued || expected_routes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rcrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcrs_pkg::LIST_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            rcrs_pkg::CFG_CHIPLET_COUNT: ring_size = data[5:0];
            rcrs_pkg::CFG_GATEWAY_COUNT: gw_count  = data[3:0];
            rcrs_pkg::CFG_GATEWAY_LIST:  gw_list   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // count registers get junk above their used bits
    task automatic set_ring(input logic [5:0] n, input logic [3:0] gc,
                            input logic [rcrs_pkg::LIST_W-1:0] list);
        logic [rcrs_pkg::LIST_W-1:0] junk;
        junk = {16'($urandom), 32'($urandom)};
        write_reg(rcrs_pkg::CFG_CHIPLET_COUNT, {junk[rcrs_pkg::LIST_W-1:6], n});
        junk = {16'($urandom), 32'($urandom)};
        write_reg(rcrs_pkg::CFG_GATEWAY_COUNT, {junk[rcrs_pkg::LIST_W-1:4], gc});
        write_reg(rcrs_pkg::CFG_GATEWAY_LIST, list);
    endtask

    function automatic rcrs_pkg::t_node pick_node(int n);
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return rcrs_pkg::t_node'($urandom_range(0, 63));
            default: return rcrs_pkg::t_node'($urandom_range(1, (n > 0) ? n : 1));
        endcase
    endfunction

    task automatic queue_random(input int count);
        int              n;
        rcrs_pkg::t_node s;
        rcrs_pkg::t_node d;
        n = ring_limit();
        repeat (count) begin
            s = pick_node(n);
            d = ($urandom_range(0, 19) == 0) ? s : pick_node(n);
            queue_query(s, d);
        end
    endtask

    task automatic random_ring(input int phase);
        logic [5:0]                  n;
        logic [3:0]                  gc;
        logic [rcrs_pkg::LIST_W-1:0] list;
        int                          top;
        case (phase)
            0:       n = 6'd1;
            1:       n = 6'd0;
            2:       n = 6'd32;
            3:       n = 6'd63;
            4:       n = 6'd2;
            5:       n = 6'd3;
            default: n = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(33, 63))
                                                     : 6'($urandom_range(4, 31));
        endcase
        case (phase)
            2:       gc = 4'd8;
            3:       gc = 4'd15;
            default: begin
                case ($urandom_range(0, 7))
                    0:       gc = 4'd0;
                    1:       gc = 4'($urandom_range(9, 15));
                    default: gc = 4'($urandom_range(1, 8));
                endcase
            end
        endcase
        top = (n > rcrs_pkg::MAX_CHIPLETS) ? rcrs_pkg::MAX_CHIPLETS
                                           : ((n == 0) ? 1 : int'(n));
        for (int i = 0; i < rcrs_pkg::MAX_GATEWAYS; i++) begin
            if ($urandom_range(0, 6) == 0) list[6*i +: 6] = 6'($urandom_range(0, 63));
            else list[6*i +: 6] = 6'($urandom_range(1, top));
        end
        set_ring(n, gc, list);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_source_node  = '0;
        i_dest_node    = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = rcrs_pkg::CFG_CHIPLET_COUNT;
        i_cfg_data     = '0;
        ring_size      = 6'd2;
        gw_count       = '0;
        gw_list        = '0;
        queries_queued = 0;
        queries_taken  = 0;
        errors         = 0;
        gap_left       = 0;
        stall_left     = 0;
        steady         = 1'b0;
        query_taken_q  = 1'b0;
        route_taken_q  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: two chiplets, empty gateway list
        queue_query(6'd1, 6'd2);
        queue_query(6'd2, 6'd1);
        queue_query(6'd0, 6'd1);
        queue_query(6'd1, 6'd0);
        queue_query(6'd1, 6'd1);
        queue_query(6'd3, 6'd1);
        queue_query(6'd63, 6'd0);
        queue_query(6'd0, 6'd63);
        wait_drained();

        // eight chiplets, gateways 3 and 7, one zero entry and one beyond the ring
        set_ring(6'd8, 4'd4, {24'd0, 6'd12, 6'd0, 6'd7, 6'd3});
        queue_query(6'd1, 6'd5);
        queue_query(6'd1, 6'd4);
        queue_query(6'd1, 6'd6);
        queue_query(6'd6, 6'd1);
        queue_query(6'd0, 6'd5);
        queue_query(6'd0, 6'd1);
        queue_query(6'd3, 6'd0);
        queue_query(6'd5, 6'd0);
        queue_query(6'd8, 6'd0);
        queue_query(6'd0, 6'd8);
        queue_query(6'd12, 6'd0);
        queue_query(6'd0, 6'd0);
        queue_query(6'd63, 6'd63);
        wait_drained();

        write_reg(CFG_SPARE, {16'($urandom), 32'($urandom)});

        for (int phase = 0; phase < 14; phase++) begin
            random_ring(phase);
            steady = ($urandom_range(0, 3) == 0);
            queue_random(86);
            wait_drained();
        end

        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
